// ===== src/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared widths, sizes, operation codes and the request type of the shared
// increment/decrement unit used by the range distinct-count block.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int POSITIONS = 4096;
  localparam int VALUES    = 65536;

  localparam int POS_W = 12;
  localparam int VAL_W = 16;
  localparam int CNT_W = 13;

  // Item operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Shared unit operation codes.
  localparam logic ALU_INC = 1'b0;
  localparam logic ALU_DEC = 1'b1;

  typedef struct packed {
    logic             op;
    logic [CNT_W-1:0] operand;
  } alu_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] result;
    logic             operand_zero;
    logic             result_zero;
  } alu_rsp_t;

endpackage

// ===== src/rdc_alu.sv =====
// ----------------------------------------------------------------------------
// rdc_alu
// Shared increment/decrement unit with zero detection. It moves window
// bounds, adjusts per-value counts and adjusts the distinct total.
// ----------------------------------------------------------------------------
module rdc_alu (
  input  rdc_pkg::alu_req_t req,
  output rdc_pkg::alu_rsp_t rsp
);

  localparam int CW = rdc_pkg::CNT_W;

  logic [CW-1:0] sum;

  always_comb begin
    if (req.op == rdc_pkg::ALU_DEC) begin
      sum = req.operand - CW'(1);
    end else begin
      sum = req.operand + CW'(1);
    end
  end

  assign rsp.result       = sum;
  assign rsp.operand_zero = (req.operand == '0);
  assign rsp.result_zero  = (sum == '0);

endmodule

// ===== src/rdc_ram.sv =====
// ----------------------------------------------------------------------------
// rdc_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module rdc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/range_distinct_count_with_updates.sv =====
// ----------------------------------------------------------------------------
// range_distinct_count_with_updates
// A write outside the window completes from idle; a write inside it first runs a leave step
// for the old value, then stores the new value and runs an enter step. A query moves the
// window one position per step; each step is a value-store read, count-table read and a
// read-modify-write through the shared unit. A reversed query answers from idle. One item
// is in flight at a time; results cannot be stalled.
// Reset: a clearing pass zeroes both memories (busy high).
// ----------------------------------------------------------------------------
module range_distinct_count_with_updates (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode,
  input  logic [rdc_pkg::POS_W-1:0]  position,
  input  logic [rdc_pkg::POS_W-1:0]  right_end,
  input  logic [rdc_pkg::VAL_W-1:0]  value,
  output logic                       done,
  output logic [rdc_pkg::CNT_W-1:0]  distinct_count,
  output logic                       bad_range
);

  // Sequencer states. Each window step runs read value, read count, update
  // count and, when the number of distinct values changes, update total.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PLAN   = 3'd2;
  localparam logic [2:0] S_RDV    = 3'd3;
  localparam logic [2:0] S_RDC    = 3'd4;
  localparam logic [2:0] S_UPD    = 3'd5;
  localparam logic [2:0] S_TOT    = 3'd6;
  localparam logic [2:0] S_WSTORE = 3'd7;

  localparam int CW = rdc_pkg::CNT_W;
  localparam int PW = rdc_pkg::POS_W;
  localparam int VW = rdc_pkg::VAL_W;

  logic [2:0]    state;
  logic [2:0]    ret_state;
  logic [VW-1:0] clr;

  // Window bounds and the count of values present in it. The window is
  // empty only straight after reset, when left sits above right.
  logic [CW-1:0] win_left;
  logic [CW-1:0] win_right;
  logic [CW-1:0] total;

  // Latched request and step operands.
  logic [CW-1:0] q_left;
  logic [CW-1:0] q_right;
  logic [VW-1:0] w_value;
  logic [PW-1:0] step_pos;
  logic          step_enter;
  logic          tot_inc;
  logic [VW-1:0] v_key;

  // Memory ports.
  logic          v_we;
  logic [PW-1:0] v_addr;
  logic [VW-1:0] v_wdata;
  logic [VW-1:0] v_rdata;
  logic          c_we;
  logic [VW-1:0] c_addr;
  logic [CW-1:0] c_wdata;
  logic [CW-1:0] c_rdata;

  rdc_pkg::alu_req_t alu_req;
  rdc_pkg::alu_rsp_t alu_rsp;

  logic          accept;
  logic          in_window;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] rgt_ext;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign pos_ext = CW'(position);
  assign rgt_ext = CW'(right_end);

  // A write lands inside the window only if the window is non-empty and
  // covers the written position.
  assign in_window = (win_left <= win_right) && (pos_ext >= win_left) &&
                     (pos_ext <= win_right);

  rdc_ram #(
    .DEPTH (rdc_pkg::POSITIONS),
    .WIDTH (VW)
  ) u_value_store (
    .clk   (clk),
    .we    (v_we),
    .addr  (v_addr),
    .wdata (v_wdata),
    .rdata (v_rdata)
  );

  rdc_ram #(
    .DEPTH (rdc_pkg::VALUES),
    .WIDTH (CW)
  ) u_count_table (
    .clk   (clk),
    .we    (c_we),
    .addr  (c_addr),
    .wdata (c_wdata),
    .rdata (c_rdata)
  );

  rdc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Operand selection for the shared unit. While planning it moves the
  // bound chosen by the priority order widen-left, widen-right,
  // narrow-left, narrow-right.
  always_comb begin
    alu_req.op      = rdc_pkg::ALU_INC;
    alu_req.operand = total;
    case (state)
      S_PLAN: begin
        if (win_left > q_left) begin
          alu_req.op      = rdc_pkg::ALU_DEC;
          alu_req.operand = win_left;
        end else if (win_right < q_right) begin
          alu_req.op      = rdc_pkg::ALU_INC;
          alu_req.operand = win_right;
        end else if (win_left < q_left) begin
          alu_req.op      = rdc_pkg::ALU_INC;
          alu_req.operand = win_left;
        end else begin
          alu_req.op      = rdc_pkg::ALU_DEC;
          alu_req.operand = win_right;
        end
      end
      S_UPD: begin
        alu_req.op      = step_enter ? rdc_pkg::ALU_INC : rdc_pkg::ALU_DEC;
        alu_req.operand = c_rdata;
      end
      S_TOT: begin
        alu_req.op      = tot_inc ? rdc_pkg::ALU_INC : rdc_pkg::ALU_DEC;
        alu_req.operand = total;
      end
      default: begin
        alu_req.op      = rdc_pkg::ALU_INC;
        alu_req.operand = total;
      end
    endcase
  end

  // Memory port selection.
  always_comb begin
    v_we    = 1'b0;
    v_addr  = step_pos;
    v_wdata = w_value;
    c_we    = 1'b0;
    c_addr  = v_key;
    c_wdata = alu_rsp.result;
    case (state)
      S_CLEAR: begin
        v_we    = (clr < VW'(rdc_pkg::POSITIONS));
        v_addr  = clr[PW-1:0];
        v_wdata = '0;
        c_we    = 1'b1;
        c_addr  = clr;
        c_wdata = '0;
      end
      S_IDLE: begin
        v_we    = accept && (opcode == rdc_pkg::OP_WRITE) && !in_window;
        v_addr  = position;
        v_wdata = value;
      end
      S_WSTORE: begin
        v_we = 1'b1;
      end
      S_RDC: begin
        c_addr = v_rdata;
      end
      S_UPD: begin
        // Leaving a value whose count is already zero changes nothing.
        c_we = step_enter || !alu_rsp.operand_zero;
      end
      default: begin
        v_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      ret_state      <= S_IDLE;
      clr            <= '0;
      win_left       <= CW'(1);
      win_right      <= '0;
      total          <= '0;
      done           <= 1'b0;
      distinct_count <= '0;
      bad_range      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + VW'(1);
          if (clr == VW'(rdc_pkg::VALUES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            step_pos <= position;
            w_value  <= value;
            q_left   <= pos_ext;
            q_right  <= rgt_ext;
            if (opcode == rdc_pkg::OP_WRITE) begin
              // A write inside the window first removes the old value.
              if (in_window) begin
                step_enter <= 1'b0;
                ret_state  <= S_WSTORE;
                state      <= S_RDV;
              end
            end else if (pos_ext > rgt_ext) begin
              done           <= 1'b1;
              distinct_count <= '0;
              bad_range      <= 1'b1;
            end else if (win_left > win_right) begin
              // Empty window: restart it holding just the left end.
              win_left   <= pos_ext;
              win_right  <= pos_ext;
              step_enter <= 1'b1;
              ret_state  <= S_PLAN;
              state      <= S_RDV;
            end else begin
              state <= S_PLAN;
            end
          end
        end
        S_PLAN: begin
          ret_state <= S_PLAN;
          if (win_left > q_left) begin
            win_left   <= alu_rsp.result;
            step_pos   <= alu_rsp.result[PW-1:0];
            step_enter <= 1'b1;
            state      <= S_RDV;
          end else if (win_right < q_right) begin
            win_right  <= alu_rsp.result;
            step_pos   <= alu_rsp.result[PW-1:0];
            step_enter <= 1'b1;
            state      <= S_RDV;
          end else if (win_left < q_left) begin
            win_left   <= alu_rsp.result;
            step_pos   <= win_left[PW-1:0];
            step_enter <= 1'b0;
            state      <= S_RDV;
          end else if (win_right > q_right) begin
            win_right  <= alu_rsp.result;
            step_pos   <= win_right[PW-1:0];
            step_enter <= 1'b0;
            state      <= S_RDV;
          end else begin
            done           <= 1'b1;
            distinct_count <= total;
            bad_range      <= 1'b0;
            state          <= S_IDLE;
          end
        end
        S_RDV: begin
          state <= S_RDC;
        end
        S_RDC: begin
          v_key <= v_rdata;
          state <= S_UPD;
        end
        S_UPD: begin
          // The total moves when a count rises from zero or falls to zero.
          if (step_enter && alu_rsp.operand_zero) begin
            tot_inc <= 1'b1;
            state   <= S_TOT;
          end else if (!step_enter && !alu_rsp.operand_zero &&
                       alu_rsp.result_zero) begin
            tot_inc <= 1'b0;
            state   <= S_TOT;
          end else begin
            state <= ret_state;
          end
        end
        S_TOT: begin
          if (tot_inc || !alu_rsp.operand_zero) begin
            total <= alu_rsp.result;
          end
          state <= ret_state;
        end
        S_WSTORE: begin
          // New value is stored this cycle and read back by the enter step.
          step_enter <= 1'b1;
          ret_state  <= S_IDLE;
          state      <= S_RDV;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A good query result always follows the final planning cycle.
  assert property (@(posedge clk) disable iff (rst)
    done && !bad_range |-> $past(state == S_PLAN))
    else $error("query result without window completion");

  // A reversed range always reports a zero count.
  assert property (@(posedge clk) disable iff (rst)
    done && bad_range |-> distinct_count == '0)
    else $error("reversed range with nonzero count");

  // After a good query the window matches the requested bounds.
  assert property (@(posedge clk) disable iff (rst)
    done && !bad_range |-> win_left == q_left && win_right == q_right)
    else $error("window does not match query bounds");

  // The distinct total can never exceed the number of positions.
  assert property (@(posedge clk) disable iff (rst)
    total <= CW'(rdc_pkg::POSITIONS))
    else $error("distinct total out of range");

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Range distinct-count testbench
// Drives writes and range queries into the distinct-count block through its
// start/busy command port. A shadow copy of the value store, the per-value
// hit counts and the sliding window predicts every query answer, and each
// done strobe is checked field by field against the oldest pending answer.
// Directed cases come first, then a random mix of window-local traffic.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // A stall longer than any correct one: it must outlast the memory-clearing pass after reset
  // and the longest query (the window swept across the whole array twice).
  localparam int STALL_LIMIT = 300000;
  // This covers any write still in flight once the last answer has been seen.
  localparam int TAIL_CYCLES = 32;

  // Stimulus and DUT connections. All inputs hold known values from time zero.
  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      start     = 1'b0;
  logic                      opcode    = rdc_pkg::OP_WRITE;
  logic [rdc_pkg::POS_W-1:0] position  = '0;
  logic [rdc_pkg::POS_W-1:0] right_end = '0;
  logic [rdc_pkg::VAL_W-1:0] value     = '0;
  logic                      busy;
  logic                      done;
  logic [rdc_pkg::CNT_W-1:0] distinct_count;
  logic                      bad_range;

  // One expected answer for a query.
  typedef struct {
    logic [rdc_pkg::CNT_W-1:0] count;
    logic                      bad;
  } answer_t;

  answer_t pending_answers[$];
  answer_t oldest;
  int      mismatches = 0;

  // Shadow state of the block: the stored values, how many window positions
  // hold each value, the window bounds and the number of values present.
  logic [rdc_pkg::VAL_W-1:0] shadow_store [rdc_pkg::POSITIONS];
  int                        value_hits   [rdc_pkg::VALUES];
  int                        win_lo;
  int                        win_hi;
  int                        live_values;

  range_distinct_count_with_updates dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .position       (position),
    .right_end      (right_end),
    .value          (value),
    .done           (done),
    .distinct_count (distinct_count),
    .bad_range      (bad_range)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow model
  // --------------------------------------------------------------------------

  // A position enters the window: its value gains a hit, and becomes present
  // if it had none.
  function automatic void enter_slot(int p);
    int v;
    v = shadow_store[p];
    value_hits[v]++;
    if (value_hits[v] == 1) live_values++;
  endfunction

  // A position leaves the window. The count never goes below zero.
  function automatic void leave_slot(int p);
    int v;
    v = shadow_store[p];
    if (value_hits[v] == 0) return;
    value_hits[v]--;
    if (value_hits[v] == 0 && live_values > 0) live_values--;
  endfunction

  // Applies one accepted transfer to the shadow state and, for a query,
  // queues the answer the block must give.
  function automatic void compute_distinct(logic op, logic [rdc_pkg::POS_W-1:0] pos,
                                           logic [rdc_pkg::POS_W-1:0] rgt,
                                           logic [rdc_pkg::VAL_W-1:0] val);
    int      p;
    int      r;
    answer_t ans;
    p = pos;
    r = rgt;
    if (op == rdc_pkg::OP_WRITE) begin
      // A write inside the window moves one hit from the old value to the
      // new one; outside it only the store changes.
      if (win_lo <= win_hi && p >= win_lo && p <= win_hi) begin
        leave_slot(p);
        shadow_store[p] = val;
        enter_slot(p);
      end else begin
        shadow_store[p] = val;
      end
      return;
    end
    if (p > r) begin
      // Reversed bounds: zero with the flag raised, window untouched.
      ans.count = '0;
      ans.bad   = 1'b1;
      pending_answers.push_back(ans);
      return;
    end
    if (win_lo > win_hi) begin
      // The window is empty only until the first proper query; it restarts
      // as the single position at the left end.
      win_lo = p;
      win_hi = p;
      enter_slot(p);
    end
    // Widen first, then narrow, exactly one position per step.
    while (win_lo > p) begin
      win_lo--;
      enter_slot(win_lo);
    end
    while (win_hi < r) begin
      win_hi++;
      enter_slot(win_hi);
    end
    while (win_lo < p) begin
      leave_slot(win_lo);
      win_lo++;
    end
    while (win_hi > r) begin
      leave_slot(win_hi);
      win_hi--;
    end
    ans.count = rdc_pkg::CNT_W'(live_values);
    ans.bad   = 1'b0;
    pending_answers.push_back(ans);
  endfunction

  // --------------------------------------------------------------------------
  // Checking and the stall watchdog
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Every done strobe is one result transfer; it is compared with the oldest
  // pending answer. Outputs are sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: count %0d bad %0b",
                                  distinct_count, bad_range));
      end else begin
        oldest = pending_answers.pop_front();
        if (distinct_count !== oldest.count)
          report_mismatch($sformatf("distinct_count got %0d want %0d",
                                    distinct_count, oldest.count));
        if (bad_range !== oldest.bad)
          report_mismatch($sformatf("bad_range got %0b want %0b",
                                    bad_range, oldest.bad));
      end
    end
  end

  // Counts cycles in which neither a command nor a result is transferred and
  // ends the run if the count reaches the limit.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Presents one command at the falling edge and waits for the rising edge at
  // which it is transferred. Start is left high, so a following call keeps
  // the port busy with no gap; hold_off lowers it.
  task automatic send_item(input logic op, input logic [rdc_pkg::POS_W-1:0] pos,
                           input logic [rdc_pkg::POS_W-1:0] rgt,
                           input logic [rdc_pkg::VAL_W-1:0] val);
    @(negedge clk);
    start     <= 1'b1;
    opcode    <= op;
    position  <= pos;
    right_end <= rgt;
    value     <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    compute_distinct(op, pos, rgt, val);
  endtask

  // Sender idles for a number of cycles.
  task automatic hold_off(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic [rdc_pkg::POS_W-1:0] clamp_pos(int p);
    if (p < 0) return '0;
    if (p > rdc_pkg::POSITIONS - 1) return rdc_pkg::POS_W'(rdc_pkg::POSITIONS - 1);
    return rdc_pkg::POS_W'(p);
  endfunction

  // Mostly a small alphabet so that values repeat inside a window, with the
  // extremes and full-width values mixed in.
  function automatic logic [rdc_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return rdc_pkg::VAL_W'($urandom_range(0, rdc_pkg::VALUES - 1));
      default: return rdc_pkg::VAL_W'($urandom_range(0, 31));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // After reset the window is empty and the store holds zeros. A reversed
  // query must not disturb it, and the first proper query restarts it.
  task automatic test_empty_window();
    send_item(rdc_pkg::OP_QUERY, 12'd3, 12'd2, 16'h0000);
    send_item(rdc_pkg::OP_QUERY, 12'd5, 12'd9, 16'hFFFF);
  endtask

  // Field extremes: writes at both ends of the array with all-ones and
  // alternating values, a write inside the window, and queries over the
  // whole array and at each end.
  task automatic test_field_extremes();
    send_item(rdc_pkg::OP_WRITE, 12'd0,    12'hFFF, 16'hFFFF);
    send_item(rdc_pkg::OP_WRITE, 12'hFFF,  12'd0,   16'hAAAA);
    send_item(rdc_pkg::OP_WRITE, 12'd7,    12'h555, 16'h5555);
    send_item(rdc_pkg::OP_QUERY, 12'd5,    12'd9,   16'h0000);
    send_item(rdc_pkg::OP_QUERY, 12'd0,    12'hFFF, 16'h0000);
    send_item(rdc_pkg::OP_QUERY, 12'd0,    12'd0,   16'h0000);
    send_item(rdc_pkg::OP_QUERY, 12'hFFF,  12'hFFF, 16'h0000);
    send_item(rdc_pkg::OP_QUERY, 12'd0,    12'hFFF, 16'hFFFF);
  endtask

  // Reversed bounds at the extremes: zero, flag set, window kept.
  task automatic test_reversed_query();
    send_item(rdc_pkg::OP_QUERY, 12'hFFF, 12'd0, 16'h0000);
    send_item(rdc_pkg::OP_QUERY, 12'd1,   12'd0, 16'h0000);
  endtask

  // Writes inside the current window, including both of its edges, followed
  // by queries that must see the adjusted counts.
  task automatic test_writes_in_window();
    send_item(rdc_pkg::OP_WRITE, 12'h800, 12'd0, 16'h1234);
    send_item(rdc_pkg::OP_WRITE, 12'd7,   12'd0, 16'h0000);
    send_item(rdc_pkg::OP_WRITE, 12'd0,   12'd0, 16'h0000);
    send_item(rdc_pkg::OP_QUERY, 12'd0,   12'hFFF, 16'h0000);
    send_item(rdc_pkg::OP_QUERY, 12'hFFE, 12'hFFF, 16'h0000);
    send_item(rdc_pkg::OP_WRITE, 12'hFFF, 12'd0, 16'h0000);
    send_item(rdc_pkg::OP_QUERY, 12'hFFE, 12'hFFF, 16'h0000);
  endtask

  // Random traffic kept close to the current window so that each query moves
  // it only a little; a few far jumps sweep the whole array. With idling on,
  // each block of 25 transfers either idles in bursts or runs flat out.
  task automatic test_random_traffic(input int items, input bit with_idle);
    int                        idle_pct;
    int                        pick;
    int                        base;
    logic                      op;
    logic [rdc_pkg::POS_W-1:0] p;
    logic [rdc_pkg::POS_W-1:0] r;
    logic [rdc_pkg::VAL_W-1:0] v;
    idle_pct = 0;
    for (int n = 0; n < items; n++) begin
      if (n % 25 == 0) idle_pct = (with_idle && $urandom_range(0, 1)) ? 30 : 0;
      if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 18));
      pick = $urandom_range(0, 127);
      v    = pick_value();
      r    = rdc_pkg::POS_W'($urandom_range(0, rdc_pkg::POSITIONS - 1));
      if (pick < 52) begin
        // Write, mostly in or just around the window.
        op = rdc_pkg::OP_WRITE;
        if (win_lo <= win_hi && $urandom_range(0, 3) != 0) begin
          base = win_lo - 4 + int'($urandom_range(0, win_hi - win_lo + 8));
          p    = clamp_pos(base);
        end else begin
          p = rdc_pkg::POS_W'($urandom_range(0, rdc_pkg::POSITIONS - 1));
        end
      end else if (pick < 60) begin
        // Reversed bounds.
        op = rdc_pkg::OP_QUERY;
        p  = rdc_pkg::POS_W'($urandom_range(1, rdc_pkg::POSITIONS - 1));
        r  = rdc_pkg::POS_W'($urandom_range(0, p - 1));
      end else if (pick < 62) begin
        // Far jump: a compact window anywhere, or two arbitrary bounds.
        op = rdc_pkg::OP_QUERY;
        p  = rdc_pkg::POS_W'($urandom_range(0, rdc_pkg::POSITIONS - 1));
        if ($urandom_range(0, 1)) r = clamp_pos(int'(p) + int'($urandom_range(0, 255)));
      end else begin
        // Small move of both bounds; may cross and give a reversed query.
        op = rdc_pkg::OP_QUERY;
        if (win_lo > win_hi) begin
          p = rdc_pkg::POS_W'($urandom_range(0, rdc_pkg::POSITIONS - 1));
          r = clamp_pos(int'(p) + int'($urandom_range(0, 40)));
        end else begin
          p = clamp_pos(win_lo + int'($urandom_range(0, 40)) - 20);
          r = clamp_pos(win_hi + int'($urandom_range(0, 40)) - 20);
        end
      end
      send_item(op, p, r, v);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = '0;
    foreach (value_hits[i]) value_hits[i] = 0;
    win_lo      = 1;
    win_hi      = 0;
    live_values = 0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_empty_window();
    test_field_extremes();
    test_reversed_query();
    test_writes_in_window();
    test_random_traffic(420, 1'b1);
    // Closing stretch with no idling at all.
    test_random_traffic(80, 1'b0);

    // Stop sending, let every pending answer arrive, then allow any trailing
    // write to finish before judging the run.
    hold_off(1);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
